### rtl/assert_macros.svh
// Assertion macros used by the checker module.
// Needs clk and rst in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define CHK_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Condition that holds on every rising edge outside reset.
`define CHK_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant check failed");

`endif

### rtl/wvn_pkg.sv
// Types, constants and arithmetic helpers of the warped value noise generator.
// No dependencies.
package wvn_pkg;

  localparam int COORD_W = 22;
  localparam int CX_W    = 28;
  localparam int IDX_W   = 12;
  localparam int CELL_W  = 5;
  localparam int VAL_W   = 24;
  localparam int MIX_W   = 41;
  localparam int WN_W    = 38;
  localparam int OFF_W   = 13;
  localparam int LATENCY = 21;

  localparam logic [31:0] HASH_X  = 32'h8DA6B343;
  localparam logic [31:0] HASH_Y  = 32'hD8163841;
  localparam logic [31:0] HASH_M1 = 32'h7FEB352D;
  localparam logic [31:0] HASH_M2 = 32'h846CA68B;

  localparam logic [31:0] SEED_WARP_X = 32'hA511E9B3;
  localparam logic [31:0] SEED_WARP_Y = 32'h63D83595;
  localparam logic [31:0] SEED_OCT4   = 32'h9E3779B9;
  localparam logic [31:0] SEED_OCT8   = 32'hBB67AE85;
  localparam logic [31:0] SEED_OCT9   = 32'h3C6EF372;
  localparam logic [31:0] SEED_OCT18  = 32'hA54FF53A;

  localparam logic [VAL_W-1:0] CELL_MAX  = 24'hFFFFFF;
  localparam logic [VAL_W-1:0] CELL_HALF = 24'h800000;
  localparam logic [WN_W-1:0]  WARP_Q16  = 38'd7864;
  localparam logic [WN_W-1:0]  WARP_DEN  = 38'd33554430;

  localparam logic [15:0] W_MACRO_LO  = 16'd45875;
  localparam logic [15:0] W_MACRO_HI  = 16'd19661;
  localparam logic [15:0] W_DETAIL_LO = 16'd42598;
  localparam logic [15:0] W_DETAIL_HI = 16'd22938;

  localparam logic [49:0] BYTE_HALF = 50'h7F_FFFF_8000;
  localparam logic [49:0] BYTE_DEN  = 50'hFF_FFFF_0000;

  typedef struct packed {
    logic [7:0] texel_x;
    logic [7:0] texel_y;
  } texel_t;

  typedef struct packed {
    logic [7:0] macro_value;
    logic [7:0] detail_value;
  } result_t;

  function automatic logic [16:0] smooth_round(input logic [31:0] tt, input logic [15:0] t);
    logic [17:0] k;
    logic [49:0] p;
    k = 18'd196608 - {1'b0, t, 1'b0};
    p = 50'(tt) * 50'(k) + 50'h8000_0000;
    return p[48:32];
  endfunction

  function automatic logic [VAL_W-1:0] lerp24(input logic [VAL_W-1:0] a,
                                              input logic [VAL_W-1:0] b,
                                              input logic [16:0] s);
    logic signed [24:0] diff;
    logic signed [42:0] acc;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    acc = $signed({3'b0, a, 16'h0}) + diff * $signed({1'b0, s}) + 43'sd32768;
    return acc[39:16];
  endfunction

  function automatic logic [OFF_W-1:0] warp_mag(input logic [WN_W-1:0] n);
    logic [OFF_W-1:0] qe;
    logic [WN_W-1:0] prod;
    logic [WN_W-1:0] r;
    qe = n[37:25];
    prod = {qe, 25'h0} - {24'h0, qe, 1'b0};
    r = n - prod;
    if (r >= WARP_DEN) begin
      qe = qe + 1'b1;
    end
    return qe;
  endfunction

  function automatic logic [7:0] to_byte(input logic [MIX_W-1:0] m);
    logic [49:0] n;
    logic [9:0] qe;
    logic [49:0] prod;
    logic [49:0] r;
    n = {1'b0, m, 8'h0} - 50'(m) + BYTE_HALF;
    qe = n[49:40];
    prod = {qe, 40'h0} - {24'h0, qe, 16'h0};
    r = n - prod;
    if (r >= BYTE_DEN) begin
      qe = qe + 1'b1;
    end
    return (qe > 10'd255) ? 8'hFF : qe[7:0];
  endfunction

endpackage

### rtl/warped_value_noise_texel_generator.sv
// Warped value noise texel generator: macro and detail noise bytes per texel.
// The done strobe follows each accepted start beat through the vld shift register.
// Throughput one texel per cycle; busy never rises, the pipeline always advances.
// Synchronous active-high reset clears the valid bits; payload registers are not reset.
// Depends on wvn_pkg and wvn_noise.
module warped_value_noise_texel_generator import wvn_pkg::*; #(
  parameter int TEXTURE_SIZE = 256
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  texel_t  texel,
  output logic    done,
  output result_t result
);

  localparam int DEPTH   = 11;
  localparam int UREC_SH = 20;
  localparam logic [35:0] UREC =
    36'(((64'd1 << 36) + 64'(TEXTURE_SIZE) - 64'd1) / 64'(TEXTURE_SIZE));

  logic [LATENCY:1]           vld;
  logic signed [COORD_W-1:0]  ud [1:DEPTH];
  logic signed [COORD_W-1:0]  vd [1:DEPTH];
  logic [43:0]                u_prod;
  logic [43:0]                v_prod;
  logic signed [COORD_W-1:0]  u_next;
  logic signed [COORD_W-1:0]  v_next;
  logic [VAL_W-1:0]           nw [2];
  logic [WN_W-1:0]            wn [2];
  logic                       wneg [2];
  logic [VAL_W:0]             mag [2];
  logic signed [COORD_W-1:0]  offs [2];
  logic signed [COORD_W-1:0]  wu;
  logic signed [COORD_W-1:0]  wv;
  logic [VAL_W-1:0]           n4, n8, n9, n18;
  logic [MIX_W-1:0]           mm;
  logic [MIX_W-1:0]           md;

  assign busy   = 1'b0;
  assign done   = vld[LATENCY];
  assign u_prod = 44'(texel.texel_x) * 44'(UREC);
  assign v_prod = 44'(texel.texel_y) * 44'(UREC);
  assign u_next = COORD_W'(u_prod[43:UREC_SH]);
  assign v_next = COORD_W'(v_prod[43:UREC_SH]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-1:1], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    ud[1] <= u_next;
    vd[1] <= v_next;
    for (int k = 2; k <= DEPTH; k++) begin
      ud[k] <= ud[k-1];
      vd[k] <= vd[k-1];
    end
  end

  wvn_noise #(.PERIOD(3), .SEED(SEED_WARP_X)) u_warp_x (
    .clk(clk), .cu(ud[1]), .cv(vd[1]), .n(nw[0])
  );
  wvn_noise #(.PERIOD(3), .SEED(SEED_WARP_Y)) u_warp_y (
    .clk(clk), .cu(ud[1]), .cv(vd[1]), .n(nw[1])
  );

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      if (nw[a] < CELL_HALF) begin
        mag[a] = {1'b0, CELL_MAX} - {nw[a], 1'b0};
      end else begin
        mag[a] = {nw[a], 1'b0} - {1'b0, CELL_MAX};
      end
      offs[a] = COORD_W'(warp_mag(wn[a]));
      if (wneg[a]) begin
        offs[a] = -offs[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      wn[a]   <= WN_W'(mag[a]) * WARP_Q16 + WN_W'(CELL_MAX);
      wneg[a] <= nw[a] < CELL_HALF;
    end
    wu <= ud[10] + offs[0];
    wv <= vd[10] + offs[1];
  end

  wvn_noise #(.PERIOD(4), .SEED(SEED_OCT4)) u_oct4 (
    .clk(clk), .cu(wu), .cv(wv), .n(n4)
  );
  wvn_noise #(.PERIOD(8), .SEED(SEED_OCT8)) u_oct8 (
    .clk(clk), .cu(wu), .cv(wv), .n(n8)
  );
  wvn_noise #(.PERIOD(9), .SEED(SEED_OCT9)) u_oct9 (
    .clk(clk), .cu(ud[DEPTH]), .cv(vd[DEPTH]), .n(n9)
  );
  wvn_noise #(.PERIOD(18), .SEED(SEED_OCT18)) u_oct18 (
    .clk(clk), .cu(ud[DEPTH]), .cv(vd[DEPTH]), .n(n18)
  );

  always_ff @(posedge clk) begin
    mm <= MIX_W'(n4) * MIX_W'(W_MACRO_LO) + MIX_W'(n8) * MIX_W'(W_MACRO_HI);
    md <= MIX_W'(n9) * MIX_W'(W_DETAIL_LO) + MIX_W'(n18) * MIX_W'(W_DETAIL_HI);
    result.macro_value  <= to_byte(mm);
    result.detail_value <= to_byte(md);
  end

endmodule

### rtl/wvn_noise.sv
// Eight-stage pipeline for one tileable value noise octave.
// Depends on wvn_pkg.
module wvn_noise import wvn_pkg::*; #(
  parameter int          PERIOD = 3,
  parameter logic [31:0] SEED   = 32'h0
) (
  input  logic                      clk,
  input  logic signed [COORD_W-1:0] cu,
  input  logic signed [COORD_W-1:0] cv,
  output logic [VAL_W-1:0]          n
);

  localparam logic signed [CX_W-1:0] PER_C = CX_W'(PERIOD);
  localparam logic [IDX_W-1:0]       PER_I = IDX_W'(PERIOD);
  localparam logic [CELL_W-1:0]      PER_W = CELL_W'(PERIOD);
  localparam logic [15:0]            RECIP = 16'(65536 / PERIOD);

  logic signed [CX_W-1:0] c1 [2];
  logic [IDX_W-1:0]       xb [2];
  logic [15:0]            t2 [2];
  logic [31:0]            tt2 [2];
  logic [CELL_W-1:0]      lo [2];
  logic [CELL_W-1:0]      hi [2];
  logic [16:0]            sm3 [2];
  logic [31:0]            hm [2][2];
  logic [16:0]            sm4 [2];
  logic [31:0]            h5 [4];
  logic [16:0]            sm5 [2];
  logic [31:0]            h6 [4];
  logic [16:0]            sm6 [2];
  logic [VAL_W-1:0]       r7 [2];
  logic [16:0]            sy7;

  logic [27:0]        qp [2];
  logic [IDX_W-1:0]   rr [2];
  logic [CELL_W-1:0]  lo_next [2];
  logic [CELL_W-1:0]  hi_next [2];
  logic [31:0]        mix5 [4];
  logic [31:0]        mix6 [4];
  logic [VAL_W-1:0]   cval [4];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      qp[a] = 28'(xb[a]) * 28'(RECIP);
      rr[a] = xb[a] - IDX_W'(qp[a][27:16] * PER_I);
      if (rr[a] >= PER_I) begin
        rr[a] = rr[a] - PER_I;
      end
      lo_next[a] = rr[a][CELL_W-1:0];
      hi_next[a] = (lo_next[a] == PER_W - 1'b1) ? '0 : lo_next[a] + 1'b1;
    end
    for (int j = 0; j < 2; j++) begin
      for (int i = 0; i < 2; i++) begin
        mix5[j*2+i] = hm[0][i] ^ hm[1][j] ^ SEED;
        mix5[j*2+i] = mix5[j*2+i] ^ (mix5[j*2+i] >> 16);
      end
    end
    for (int k = 0; k < 4; k++) begin
      mix6[k] = h5[k] ^ (h5[k] >> 15);
      cval[k] = VAL_W'(h6[k] ^ (h6[k] >> 16));
    end
  end

  always_ff @(posedge clk) begin
    c1[0] <= CX_W'(cu) * PER_C;
    c1[1] <= CX_W'(cv) * PER_C;
    for (int a = 0; a < 2; a++) begin
      xb[a]    <= c1[a][CX_W-1:16] + PER_I;
      t2[a]    <= c1[a][15:0];
      tt2[a]   <= 32'(c1[a][15:0]) * 32'(c1[a][15:0]);
      lo[a]    <= lo_next[a];
      hi[a]    <= hi_next[a];
      sm3[a]   <= smooth_round(tt2[a], t2[a]);
      sm4[a]   <= sm3[a];
      sm5[a]   <= sm4[a];
      sm6[a]   <= sm5[a];
    end
    hm[0][0] <= 32'(lo[0]) * HASH_X;
    hm[0][1] <= 32'(hi[0]) * HASH_X;
    hm[1][0] <= 32'(lo[1]) * HASH_Y;
    hm[1][1] <= 32'(hi[1]) * HASH_Y;
    for (int k = 0; k < 4; k++) begin
      h5[k] <= mix5[k] * HASH_M1;
      h6[k] <= mix6[k] * HASH_M2;
    end
    r7[0] <= lerp24(cval[0], cval[1], sm6[0]);
    r7[1] <= lerp24(cval[2], cval[3], sm6[0]);
    sy7   <= sm6[1];
    n     <= lerp24(r7[0], r7[1], sy7);
  end

endmodule

### rtl/wvn_checker.sv
// Port-level checks of the texel generator and their bind.
// Depends on wvn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wvn_checker import wvn_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  `CHK_ALWAYS(never_busy, !busy)
  `CHK_IMPLY(beat_gives_result, start && !busy, ##21 done)
  `CHK_IMPLY(result_has_beat, done, $past(start && !busy, 21))
  `CHK_IMPLY(result_known, done, !$isunknown(result))

endmodule

bind warped_value_noise_texel_generator wvn_checker u_wvn_checker (.*);

### dv/tb_warped_value_noise_texel_generator.sv
// Testbench of the warped value noise texel generator: random and corner texels,
// results predicted in-bench and checked in order against the done strobe.
// Depends on wvn_pkg and warped_value_noise_texel_generator.
module tb_warped_value_noise_texel_generator;
  import wvn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TEX = 256;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  texel_t  texel = '0;
  logic    done;
  result_t result;

  texel_t  pending_texels[$];
  result_t expected_bytes[$];
  int      idle_pct = 0;
  bit      hold_off = 1'b0;
  bit      feed_over = 1'b0;
  int      errors = 0;

  warped_value_noise_texel_generator #(.TEXTURE_SIZE(TEX)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .texel(texel), .done(done), .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned lattice_value(longint unsigned x, longint unsigned y,
                                                    bit [31:0] seed);
    bit [31:0] h;
    h = (x[31:0] * 32'h8DA6B343) ^ (y[31:0] * 32'hD8163841) ^ seed;
    h ^= h >> 16;
    h *= 32'h7FEB352D;
    h ^= h >> 15;
    h *= 32'h846CA68B;
    h ^= h >> 16;
    return longint'(h[23:0]);
  endfunction

  function automatic longint unsigned ease(longint unsigned t);
    return (t * t * (196608 - 2 * t) + 64'h8000_0000) >> 32;
  endfunction

  function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                            longint unsigned s);
    return (a * (65536 - s) + b * s + 32768) >> 16;
  endfunction

  function automatic longint unsigned tile_noise(longint cx, longint cy, int period,
                                                 bit [31:0] seed);
    longint fx, fy, ix, iy, x0, y0, x1, y1;
    longint unsigned sx, sy, r0, r1;
    fx = cx & 64'hFFFF;
    fy = cy & 64'hFFFF;
    ix = (cx - fx) / 65536;
    iy = (cy - fy) / 65536;
    x0 = ix % period;
    if (x0 < 0) x0 += period;
    y0 = iy % period;
    if (y0 < 0) y0 += period;
    x1 = (x0 + 1) % period;
    y1 = (y0 + 1) % period;
    sx = ease(fx);
    sy = ease(fy);
    r0 = blend(lattice_value(x0, y0, seed), lattice_value(x1, y0, seed), sx);
    r1 = blend(lattice_value(x0, y1, seed), lattice_value(x1, y1, seed), sx);
    return blend(r0, r1, sy);
  endfunction

  function automatic longint warp_shift(longint unsigned n);
    longint d, q;
    longint unsigned mag;
    d = 2 * longint'(n) - 16777215;
    mag = longint'(d < 0 ? -d : d) * 7864;
    q = longint'((mag + 16777215) / 33554430);
    return d < 0 ? -q : q;
  endfunction

  function automatic bit [7:0] round_byte(longint unsigned m);
    longint unsigned den, b;
    den = 64'd16777215 * 64'd65536;
    b = (m * 255 + den / 2) / den;
    return b > 255 ? 8'hFF : b[7:0];
  endfunction

  function automatic result_t texel_bytes(texel_t tx);
    longint u, v, wu, wv;
    longint unsigned m, d;
    result_t r;
    u = (longint'(tx.texel_x) << 16) / TEX;
    v = (longint'(tx.texel_y) << 16) / TEX;
    wu = u + warp_shift(tile_noise(u * 3, v * 3, 3, 32'hA511E9B3));
    wv = v + warp_shift(tile_noise(u * 3, v * 3, 3, 32'h63D83595));
    m = tile_noise(wu * 4, wv * 4, 4, 32'h9E3779B9) * 45875 +
        tile_noise(wu * 8, wv * 8, 8, 32'hBB67AE85) * 19661;
    d = tile_noise(u * 9, v * 9, 9, 32'h3C6EF372) * 42598 +
        tile_noise(u * 18, v * 18, 18, 32'hA54FF53A) * 22938;
    r.macro_value = round_byte(m);
    r.detail_value = round_byte(d);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_bytes.push_back(texel_bytes(texel));
      end
      if (start && busy) begin
        // hold the beat until taken
      end else if (!hold_off && pending_texels.size() > 0 &&
                   $urandom_range(99, 0) >= idle_pct) begin
        texel <= pending_texels.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual %h/%h", $time,
                 result.macro_value, result.detail_value);
        errors++;
      end else begin
        result_t e;
        e = expected_bytes.pop_front();
        if (result.macro_value !== e.macro_value) begin
          $display("%0t macro_value: expected %h, actual %h", $time,
                   e.macro_value, result.macro_value);
          errors++;
        end
        if (result.detail_value !== e.detail_value) begin
          $display("%0t detail_value: expected %h, actual %h", $time,
                   e.detail_value, result.detail_value);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_texels.size() > 0 || start) @(posedge clk);
    while (expected_bytes.size() > 0) @(posedge clk);
  endtask

  initial begin
    texel_t t;
    int phase_pct[4] = '{0, 54, 0, 33};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (phase_pct[i]) begin
      idle_pct = phase_pct[i];
      if (i == 0) begin
        for (int k = 0; k < 4; k++) begin
          t.texel_x = (k & 1) ? 8'hFF : 8'h00;
          t.texel_y = (k & 2) ? 8'hFF : 8'h00;
          pending_texels.push_back(t);
        end
        for (int k = 0; k < 8; k++) begin
          t.texel_x = 8'(1 << k);
          t.texel_y = ~8'(1 << k);
          pending_texels.push_back(t);
        end
        pending_texels.push_back('{texel_x: 8'd64, texel_y: 8'd192});
        pending_texels.push_back('{texel_x: 8'd128, texel_y: 8'd85});
        pending_texels.push_back('{texel_x: 8'd1, texel_y: 8'd254});
      end
      for (int k = 0; k < 450; k++) begin
        t.texel_x = 8'($urandom);
        t.texel_y = 8'($urandom);
        pending_texels.push_back(t);
      end
      if (i == 1) begin
        while (pending_texels.size() > 225) @(posedge clk);
        hold_off = 1'b1;
        @(posedge clk);
        while (start || expected_bytes.size() > 0) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #200us;
    $display("Mismatches found");
    $finish;
  end
endmodule

### sim.f
+incdir+rtl
rtl/wvn_pkg.sv
rtl/wvn_noise.sv
rtl/warped_value_noise_texel_generator.sv
rtl/wvn_checker.sv
dv/tb_warped_value_noise_texel_generator.sv
